// ===== hdl/ccol_pkg.sv =====
// Shared types and constants for the circle collision test pipeline.
// Used by the top level; depends on nothing else.
package ccol_pkg;

	localparam int DistW = 32;
	localparam int QuotW = 15;
	localparam logic [15:0] MinDistReset = 16'd66;
	localparam logic [14:0] NormalOne = 15'd16384;

	typedef struct packed {
		logic signed [31:0] self_x;
		logic signed [31:0] self_z;
		logic [23:0] self_width;
		logic [23:0] self_length;
		logic signed [31:0] other_x;
		logic signed [31:0] other_z;
		logic [23:0] other_width;
		logic [23:0] other_length;
	} item_t;

	typedef struct packed {
		logic hit;
		logic [30:0] overlap;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_z;
	} result_t;

	// Carried alongside the square roots.
	typedef struct packed {
		logic sx;
		logic sz;
		logic far;
		logic [30:0] ax;
		logic [30:0] az;
	} geo_t;

	// Carried alongside the normal divisions.
	typedef struct packed {
		logic hit;
		logic coinc;
		logic sx;
		logic sz;
		logic [30:0] overlap;
	} hitinfo_t;

endpackage

// ===== hdl/ccol_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Stand-alone; no package needed.
module ccol_sqrt_pipe #(
	parameter int RootW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [2*RootW-1:0]   radicand,
	output logic                 out_valid,
	output logic [RootW-1:0]     root
);

	logic [2*RootW-1:0] rad_s  [RootW];
	logic [RootW-1:0]   rem_s  [RootW];
	logic [RootW-1:0]   root_s [RootW];
	logic               vld_s  [RootW];

	for (genvar g = 0; g < RootW; g++) begin : g_stage
		logic [2*RootW-1:0] rad_p;
		logic [RootW-1:0]   rem_p;
		logic [RootW-1:0]   root_p;
		logic               vld_p;
		logic [RootW+1:0]   cur;
		logic [RootW+1:0]   trial;
		logic [RootW+1:0]   diff;

		if (g == 0) begin : g_first
			assign rad_p  = radicand;
			assign rem_p  = '0;
			assign root_p = '0;
			assign vld_p  = in_valid;
		end else begin : g_next
			assign rad_p  = rad_s[g-1];
			assign rem_p  = rem_s[g-1];
			assign root_p = root_s[g-1];
			assign vld_p  = vld_s[g-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		always_comb begin
			cur   = {rem_p, rad_p[2*RootW-1 -: 2]};
			trial = {root_p, 2'b01};
			diff  = cur - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[g] <= rad_p << 2;
			if (cur >= trial) begin
				rem_s[g]  <= diff[RootW-1:0];
				root_s[g] <= {root_p[RootW-2:0], 1'b1};
			end else begin
				rem_s[g]  <= cur[RootW-1:0];
				root_s[g] <= {root_p[RootW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[RootW-1];
	assign root      = root_s[RootW-1];

`ifndef SYNTHESIS
	a_sqrt_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##RootW out_valid)
		else $error("square root word lost in the pipeline");
`endif

endmodule

// ===== hdl/ccol_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Stand-alone; the numerator must be below den * 2**QuotW.
module ccol_div_pipe #(
	parameter int DenW  = 32,
	parameter int QuotW = 15
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [DenW+QuotW-1:0]   num,
	input  logic [DenW-1:0]         den,
	output logic                    out_valid,
	output logic [QuotW-1:0]        quot
);

	localparam int NumW = DenW + QuotW;

	logic [NumW-1:0]  rem_s [QuotW];
	logic [DenW-1:0]  den_s [QuotW];
	logic [QuotW-1:0] q_s   [QuotW];
	logic             vld_s [QuotW];

	for (genvar g = 0; g < QuotW; g++) begin : g_stage
		logic [NumW-1:0]  rem_p;
		logic [DenW-1:0]  den_p;
		logic [QuotW-1:0] q_p;
		logic             vld_p;
		logic [NumW-1:0]  dsh;

		if (g == 0) begin : g_first
			assign rem_p = num;
			assign den_p = den;
			assign q_p   = '0;
			assign vld_p = in_valid;
		end else begin : g_next
			assign rem_p = rem_s[g-1];
			assign den_p = den_s[g-1];
			assign q_p   = q_s[g-1];
			assign vld_p = vld_s[g-1];
		end

		assign dsh = NumW'(den_p) << (QuotW - 1 - g);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			den_s[g] <= den_p;
			if (rem_p >= dsh) begin
				rem_s[g] <= rem_p - dsh;
				q_s[g]   <= {q_p[QuotW-2:0], 1'b1};
			end else begin
				rem_s[g] <= rem_p;
				q_s[g]   <= {q_p[QuotW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[QuotW-1];
	assign quot      = q_s[QuotW-1];

`ifndef SYNTHESIS
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##QuotW out_valid)
		else $error("division word lost in the pipeline");
`endif

endmodule

// ===== hdl/circle_collision_test_top.sv =====
// Circle collision test: bounding-circle overlap of two ground-plane footprints.
// Depends on ccol_pkg, ccol_sqrt_pipe and ccol_div_pipe.
//
// A new word can be started in every cycle; busy is always low. Each result
// appears on result with done high, in the order of the starts. The pipeline
// is built from the 32-stage square root (one root bit per stage)
// and the 15-stage normal divider (one quotient bit per stage), plus five
// stages of differences, squares, sums, classification and output. Results
// cannot be held off. Write min_distance only while no word is in flight.
module circle_collision_test_top
	import ccol_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	logic [15:0] min_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= MinDistReset;
		end else if (cfg_we) begin
			min_dist_q <= cfg_data;
		end
	end

	assign busy = 1'b0;

	// Stage 1: centre differences and their magnitudes.
	logic signed [32:0] dx_c, dz_c;
	logic [32:0]        ax_c, az_c;
	logic               vld_s1;
	geo_t               geo_s1;
	logic [23:0]        wa_s1, la_s1, wb_s1, lb_s1;

	always_comb begin
		dx_c = 33'(item.other_x) - 33'(item.self_x);
		dz_c = 33'(item.other_z) - 33'(item.self_z);
		ax_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
		az_c = dz_c[32] ? 33'(-dz_c) : 33'(dz_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		geo_s1.sx  <= dx_c[32];
		geo_s1.sz  <= dz_c[32];
		geo_s1.far <= ax_c[32] | ax_c[31] | az_c[32] | az_c[31];
		geo_s1.ax  <= ax_c[30:0];
		geo_s1.az  <= az_c[30:0];
		wa_s1      <= item.self_width;
		la_s1      <= item.self_length;
		wb_s1      <= item.other_width;
		lb_s1      <= item.other_length;
	end

	// Stage 2: squares.
	logic        vld_s2;
	geo_t        geo_s2;
	logic [61:0] axx_s2, azz_s2;
	logic [47:0] wwa_s2, lla_s2, wwb_s2, llb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		geo_s2 <= geo_s1;
		axx_s2 <= 62'(geo_s1.ax) * 62'(geo_s1.ax);
		azz_s2 <= 62'(geo_s1.az) * 62'(geo_s1.az);
		wwa_s2 <= 48'(wa_s1) * 48'(wa_s1);
		lla_s2 <= 48'(la_s1) * 48'(la_s1);
		wwb_s2 <= 48'(wb_s1) * 48'(wb_s1);
		llb_s2 <= 48'(lb_s1) * 48'(lb_s1);
	end

	// Stage 3: sums of squares.
	logic        vld_s3;
	geo_t        geo_s3;
	logic [62:0] dsq_s3;
	logic [48:0] rsqa_s3, rsqb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		geo_s3  <= geo_s2;
		dsq_s3  <= 63'(axx_s2) + 63'(azz_s2);
		rsqa_s3 <= 49'(wwa_s2) + 49'(lla_s2);
		rsqb_s3 <= 49'(wwb_s2) + 49'(llb_s2);
	end

	// Square roots of distance and both diagonals.
	logic             vld_root;
	logic [DistW-1:0] dist_root, rta_root, rtb_root;

	ccol_sqrt_pipe #(.RootW(DistW)) u_sqrt_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.radicand  ((2*DistW)'(dsq_s3)),
		.out_valid (vld_root),
		.root      (dist_root)
	);

	ccol_sqrt_pipe #(.RootW(DistW)) u_sqrt_rad_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.radicand  ((2*DistW)'(rsqa_s3)),
		.out_valid (),
		.root      (rta_root)
	);

	ccol_sqrt_pipe #(.RootW(DistW)) u_sqrt_rad_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.radicand  ((2*DistW)'(rsqb_s3)),
		.out_valid (),
		.root      (rtb_root)
	);

	geo_t geo_dly [DistW];

	always_ff @(posedge clk) begin
		geo_dly[0] <= geo_s3;
		for (int i = 1; i < DistW; i++) begin
			geo_dly[i] <= geo_dly[i-1];
		end
	end

	// Stage 4: classify and set up the normal divisions.
	geo_t                   geo_r;
	logic [25:0]            rsum_c;
	logic                   coinc_c, ord_c, hit_c;
	logic [30:0]            ovl_c;
	logic                   vld_s4;
	hitinfo_t               info_s4;
	logic [DistW-1:0]       d_s4;
	logic [DistW+QuotW-1:0] numx_s4, numz_s4;

	always_comb begin
		geo_r   = geo_dly[DistW-1];
		rsum_c  = 26'(rta_root[DistW-1:1]) + 26'(rtb_root[DistW-1:1]);
		coinc_c = dist_root <= DistW'(min_dist_q);
		ord_c   = dist_root < DistW'(rsum_c);
		hit_c   = !geo_r.far && (coinc_c || ord_c);
		if (!hit_c) begin
			ovl_c = '0;
		end else if (coinc_c) begin
			ovl_c = 31'(rsum_c);
		end else begin
			ovl_c = 31'(rsum_c - dist_root[25:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_root;
		end
	end

	// The half divisor added to the numerator rounds the quotient to nearest.
	always_ff @(posedge clk) begin
		info_s4.hit     <= hit_c;
		info_s4.coinc   <= coinc_c;
		info_s4.sx      <= geo_r.sx;
		info_s4.sz      <= geo_r.sz;
		info_s4.overlap <= ovl_c;
		d_s4            <= dist_root;
		numx_s4 <= (DistW+QuotW)'({geo_r.ax, 14'b0}) + (DistW+QuotW)'(dist_root >> 1);
		numz_s4 <= (DistW+QuotW)'({geo_r.az, 14'b0}) + (DistW+QuotW)'(dist_root >> 1);
	end

	logic             vld_div;
	logic [QuotW-1:0] qx_div, qz_div;

	ccol_div_pipe #(.DenW(DistW), .QuotW(QuotW)) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.num       (numx_s4),
		.den       (d_s4),
		.out_valid (vld_div),
		.quot      (qx_div)
	);

	ccol_div_pipe #(.DenW(DistW), .QuotW(QuotW)) u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.num       (numz_s4),
		.den       (d_s4),
		.out_valid (),
		.quot      (qz_div)
	);

	hitinfo_t info_dly [QuotW];

	always_ff @(posedge clk) begin
		info_dly[0] <= info_s4;
		for (int i = 1; i < QuotW; i++) begin
			info_dly[i] <= info_dly[i-1];
		end
	end

	// Output stage: sign, special cases and the result register.
	hitinfo_t   info_r;
	logic [14:0] qx_c, qz_c;
	result_t    res_c;

	always_comb begin
		info_r = info_dly[QuotW-1];
		qx_c   = (qx_div > NormalOne) ? NormalOne : qx_div;
		qz_c   = (qz_div > NormalOne) ? NormalOne : qz_div;
		res_c.hit     = info_r.hit;
		res_c.overlap = info_r.overlap;
		if (!info_r.hit) begin
			res_c.normal_x = '0;
			res_c.normal_z = '0;
		end else if (info_r.coinc) begin
			res_c.normal_x = 16'(NormalOne);
			res_c.normal_z = '0;
		end else begin
			res_c.normal_x = info_r.sx ? -16'(qx_c) : 16'(qx_c);
			res_c.normal_z = info_r.sz ? -16'(qz_c) : 16'(qz_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_div;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_c;
	end

`ifndef SYNTHESIS
	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.overlap == '0 && result.normal_x == '0
			&& result.normal_z == '0)
		else $error("miss word carries nonzero overlap or normal");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> result.normal_x <= 16'sd16384
			&& result.normal_x >= -16'sd16384 && result.normal_z <= 16'sd16384
			&& result.normal_z >= -16'sd16384)
		else $error("normal component out of unit range");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##52 done)
		else $error("started word did not complete on time");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for circle_collision_test_top: directed table, then random pairs.
// Depends on ccol_pkg and the RTL; results are checked against a local predictor.
module tb;
	import ccol_pkg::*;

	localparam int Latency = 52;
	localparam int NumRandom = 1700;
	localparam longint CycleLimit = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;

	circle_collision_test_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [15:0] coinc_limit = MinDistReset;
	result_t pending_results[$];
	int mismatches = 0;
	int words_sent = 0;
	int hits_seen = 0;
	longint cycles = 0;

	typedef struct {
		item_t w;
		bit checked;
		result_t r;
	} vec_t;

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] half_diag(logic [23:0] w, logic [23:0] l);
		logic [63:0] s;
		s = {40'd0, w} * {40'd0, w} + {40'd0, l} * {40'd0, l};
		return root64(s) >> 1;
	endfunction

	function automatic logic [15:0] unit_comp(longint c, logic [63:0] d);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (c < 0) ? -c : c;
		q = (mag * 64'd16384 + (d >> 1)) / d;
		if (q > 64'd16384) q = 64'd16384;
		if (c < 0) q = -q;
		return q[15:0];
	endfunction

	function automatic result_t predict_contact(item_t w);
		result_t r;
		longint dx;
		longint dz;
		logic [63:0] ax;
		logic [63:0] az;
		logic [63:0] rsum;
		logic [63:0] d;
		r = '0;
		dx = longint'(w.other_x) - longint'(w.self_x);
		dz = longint'(w.other_z) - longint'(w.self_z);
		ax = (dx < 0) ? -dx : dx;
		az = (dz < 0) ? -dz : dz;
		rsum = half_diag(w.self_width, w.self_length) + half_diag(w.other_width, w.other_length);
		if (ax < 64'h8000_0000 && az < 64'h8000_0000) begin
			d = root64(ax * ax + az * az);
			if (d <= {48'd0, coinc_limit}) begin
				r.hit = 1'b1;
				r.overlap = rsum[30:0];
				r.normal_x = 16'sd16384;
			end else if (d < rsum) begin
				r.hit = 1'b1;
				r.overlap = rsum[30:0] - d[30:0];
				r.normal_x = unit_comp(dx, d);
				r.normal_z = unit_comp(dz, d);
			end
		end
		return r;
	endfunction

	// Results cannot be stalled, so every strobe is checked at the edge.
	always @(posedge clk) begin
		result_t want;
		cycles <= cycles + 1;
		if (done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				want = pending_results.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit=%b ov=%h nx=%h nz=%h, got hit=%b ov=%h nx=%h nz=%h",
							want.hit, want.overlap, want.normal_x, want.normal_z,
							result.hit, result.overlap, result.normal_x, result.normal_z);
				end
				if (want.hit) hits_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("timeout with %0d words outstanding", pending_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Start stays high between back-to-back words and drops only for a gap.
	task automatic send_word(item_t w, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_contact(w));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_and_set(logic [15:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (Latency + 2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		coinc_limit = v;
	endtask

	function automatic logic [31:0] rand_coord(logic [31:0] base);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return base + ($urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 200) - 100);
			default: return base + {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
		endcase
	endfunction

	function automatic logic [23:0] rand_size();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 255));
			default: return 24'($urandom_range(0, 24'h7_FFFF));
		endcase
	endfunction

	function automatic item_t random_pair();
		item_t w;
		w.self_x = $urandom;
		w.self_z = $urandom;
		w.self_width = rand_size();
		w.self_length = rand_size();
		w.other_x = rand_coord(w.self_x);
		w.other_z = rand_coord(w.self_z);
		w.other_width = rand_size();
		w.other_length = rand_size();
		return w;
	endfunction

	function automatic vec_t mk(int sx, int sz, int sw, int sl, int ox, int oz,
			int ow, int ol, bit chk, result_t r);
		vec_t v;
		v.w = '{sx, sz, sw[23:0], sl[23:0], ox, oz, ow[23:0], ol[23:0]};
		v.checked = chk;
		v.r = r;
		return v;
	endfunction

	initial begin
		vec_t stim[$];
		result_t none;
		result_t got;
		none = '0;
		// Coincident centers and the coincidence threshold: overlap is the radius sum, normal points along x.
		stim.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, '{1'b1, 31'd0, 16'sd16384, 16'sd0}));
		stim.push_back(mk(5, 5, 'h20000, 0, 5, 5, 0, 'h20000, 1,
			'{1'b1, 31'h20000, 16'sd16384, 16'sd0}));
		stim.push_back(mk(0, 0, 0, 0, 66, 0, 0, 0, 1, '{1'b1, 31'd0, 16'sd16384, 16'sd0}));
		stim.push_back(mk(0, 0, 0, 0, 67, 0, 0, 0, 1, none));
		// Far apart on either axis, then coincident at the most negative corner with the largest sizes.
		stim.push_back(mk(32'h8000_0000, 0, 24'hFFFFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 0,
			24'hFFFFFF, 24'hFFFFFF, 1, none));
		stim.push_back(mk(0, 32'h7FFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 32'h8000_0000,
			24'hFFFFFF, 24'hFFFFFF, 1, none));
		stim.push_back(mk(32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 24'hFFFFFF,
			32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 24'hFFFFFF, 1,
			'{1'b1, 31'h016A_09E4, 16'sd16384, 16'sd0}));
		// Ordinary hits in each direction, checked by the predictor, then a miss with tiny footprints.
		stim.push_back(mk(0, 0, 'h40000, 'h40000, 'h10000, 0, 'h40000, 'h40000, 0, none));
		stim.push_back(mk(0, 0, 'h40000, 'h40000, -'h10000, 0, 'h40000, 'h40000, 0, none));
		stim.push_back(mk(0, 0, 'h40000, 'h40000, 0, 'h10000, 'h40000, 'h40000, 0, none));
		stim.push_back(mk(0, 0, 'h40000, 'h40000, 0, -'h10000, 'h40000, 'h40000, 0, none));
		stim.push_back(mk(100, -300, 'h30000, 'h10000, -'h8000, 'h9000, 'h20000, 'h50000, 0, none));
		stim.push_back(mk(32'h7FFF_0000, 32'h7FFF_0000, 24'hFFFFFF, 24'hFFFFFF,
			32'h7F00_0000, 32'h7F00_0000, 24'hFFFFFF, 24'hFFFFFF, 0, none));
		stim.push_back(mk(0, 0, 1, 1, 'h20000, 'h20000, 1, 1, 1, none));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim[i]) begin
			got = predict_contact(stim[i].w);
			if (stim[i].checked && got !== stim[i].r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: expected %h, predictor gives %h", i, stim[i].r, got);
			end
			send_word(stim[i].w, $urandom_range(0, 1));
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: drain_and_set(16'd0);
				1: drain_and_set(16'hFFFF);
				2: drain_and_set(16'($urandom));
				default: drain_and_set(MinDistReset);
			endcase
			for (int n = 0; n < NumRandom / 4; n++) begin
				// Runs of back-to-back words alternate with random gaps.
				send_word(random_pair(), (n % 100 < 40) ? 0 : $urandom_range(0, 5));
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (Latency + 10) @(negedge clk);
		$display("Sent %0d words over four threshold settings, %0d hits among them.",
			words_sent, hits_seen);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
